### design/dqe_pkg.sv
// Shared types and constants for the bounded double-ended queue.
package dqe_pkg;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED_FRONT = 3'd0,
      ST_PUSHED_BACK  = 3'd1,
      ST_POPPED_FRONT = 3'd2,
      ST_POPPED_BACK  = 3'd3,
      ST_FULL         = 3'd4,
      ST_EMPTY        = 3'd5
   } status_type;

   // Write strobe and data presented at the ring's insertion point
   typedef struct packed {
      logic              wr;
      logic [DATA_W-1:0] data;
   } tap_wr_type;

endpackage

### design/dqe_cell.sv
// One storage cell of the rotating ring: holds an entry and passes it on each cycle.
module dqe_cell (
   input  logic                      clock,
   input  logic [dqe_pkg::DATA_W-1:0] d_in,
   output logic [dqe_pkg::DATA_W-1:0] q_out
);
   import dqe_pkg::*;

   logic [DATA_W-1:0] data_ff;

   // Take the neighbor's entry every cycle
   always_ff @(posedge clock) begin
      data_ff <= d_in;
   end

   assign q_out = data_ff;

endmodule

### design/dqe_ring.sv
// Ring of cells that rotates the stored entries past a single read/write tap.
module dqe_ring #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  dqe_pkg::tap_wr_type        tap_wr,
   output logic [dqe_pkg::DATA_W-1:0] tap_rd_data
);
   import dqe_pkg::*;

   logic [DATA_W-1:0] cell_d [DEPTH];
   logic [DATA_W-1:0] cell_q [DEPTH];

   // Close the ring; replace the entry passing the tap on a write
   assign cell_d[0] = tap_wr.wr ? tap_wr.data : cell_q[DEPTH-1];

   genvar g;
   generate
      for (g = 1; g < DEPTH; g++) begin : g_link
         assign cell_d[g] = cell_q[g-1];
      end
      for (g = 0; g < DEPTH; g++) begin : g_cell
         dqe_cell u_cell (
            .clock (clock),
            .d_in  (cell_d[g]),
            .q_out (cell_q[g])
         );
      end
   endgenerate

   assign tap_rd_data = cell_q[DEPTH-1];

endmodule

### design/bounded_double_ended_queue.sv
// Bounded double-ended queue built on a rotating ring of storage cells.
// A refused request (full or empty) completes without waiting for the ring; otherwise the
// request waits for its slot to rotate to the tap.
// One request in flight at a time: a new request is accepted only once the previous one completes.
// Reset: front pointer, count, rotation counter and handshakes clear; capacity resets to 16.
// Cell contents are not reset; only previously written entries are ever read.
module bounded_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dqe_pkg::CAP_W-1:0]          csr_capacity,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dqe_pkg::OP_W-1:0]           req_operation,
   input  logic signed [dqe_pkg::DATA_W-1:0]  req_push_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dqe_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [dqe_pkg::DATA_W-1:0]  rsp_pop_value
);
   import dqe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [CAP_W-1:0]    capacity_ff;
   logic [PTR_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    tap_slot_ff;
   logic                busy_ff;
   status_type          status_ff, status_in;
   logic [PTR_W-1:0]    target_ff, target_in;
   logic [DATA_W-1:0]   value_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [DATA_W-1:0]   rsp_value_ff;

   logic [SUM_W-1:0]    back_sum;
   logic [SUM_W-1:0]    last_sum;
   logic [PTR_W-1:0]    back_slot, last_slot, front_prev, front_next, tap_next;
   logic                is_full, is_empty, refused, at_slot, done, req_take;
   logic                is_push, is_pop;
   tap_wr_type          tap_wr;
   logic [DATA_W-1:0]   tap_rd_data;
   op_type              req_op;

   assign req_op = op_type'(req_operation);

   // Ring slot arithmetic, modulo DEPTH
   assign back_sum   = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign last_sum   = back_sum - SUM_W'(1);
   assign back_slot  = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(back_sum);
   assign last_slot  = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(last_sum);
   assign front_prev = (front_ff == '0) ? PTR_LAST : front_ff - PTR_W'(1);
   assign front_next = (front_ff == PTR_LAST) ? '0 : front_ff + PTR_W'(1);
   assign tap_next   = (tap_slot_ff == PTR_LAST) ? '0 : tap_slot_ff + PTR_W'(1);

   // Full when count reaches min(capacity, DEPTH)
   assign is_full  = (CMP_W'(count_ff) >= CMP_W'(capacity_ff)) ||
                     (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Decide status and target slot for a new request
   always_comb begin
      status_in = ST_EMPTY;
      target_in = front_ff;
      unique case (req_op)
         OP_PUSH_FRONT: begin
            status_in = is_full ? ST_FULL : ST_PUSHED_FRONT;
            target_in = front_prev;
         end
         OP_PUSH_BACK: begin
            status_in = is_full ? ST_FULL : ST_PUSHED_BACK;
            target_in = back_slot;
         end
         OP_POP_FRONT: begin
            status_in = is_empty ? ST_EMPTY : ST_POPPED_FRONT;
            target_in = front_ff;
         end
         OP_POP_BACK: begin
            status_in = is_empty ? ST_EMPTY : ST_POPPED_BACK;
            target_in = last_slot;
         end
         default: begin
            status_in = ST_EMPTY;
            target_in = front_ff;
         end
      endcase
   end

   assign refused  = (status_ff == ST_FULL) || (status_ff == ST_EMPTY);
   assign at_slot  = (tap_slot_ff == target_ff);
   assign done     = busy_ff && (refused || at_slot) && (!rsp_valid_ff || rsp_ready);
   assign is_push  = (status_ff == ST_PUSHED_FRONT) || (status_ff == ST_PUSHED_BACK);
   assign is_pop   = (status_ff == ST_POPPED_FRONT) || (status_ff == ST_POPPED_BACK);
   assign req_take = req_valid && req_ready;

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;

   // Write the pushed value as its slot passes the tap
   assign tap_wr.wr   = done && is_push;
   assign tap_wr.data = value_ff;

   dqe_ring #(.DEPTH(DEPTH)) u_ring (
      .clock       (clock),
      .tap_wr      (tap_wr),
      .tap_rd_data (tap_rd_data)
   );

   // Advance front pointer and count on completion
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (done) begin
         case (status_ff)
            ST_PUSHED_FRONT: begin
               front_in = target_ff;
               count_in = count_ff + CNT_W'(1);
            end
            ST_PUSHED_BACK: begin
               count_in = count_ff + CNT_W'(1);
            end
            ST_POPPED_FRONT: begin
               front_in = front_next;
               count_in = count_ff - CNT_W'(1);
            end
            ST_POPPED_BACK: begin
               count_in = count_ff - CNT_W'(1);
            end
            default: begin
               front_in = front_ff;
               count_in = count_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         front_ff     <= '0;
         count_ff     <= '0;
         tap_slot_ff  <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         front_ff    <= front_in;
         count_ff    <= count_in;
         tap_slot_ff <= tap_next;
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request and produce the response
   always_ff @(posedge clock) begin
      if (req_take) begin
         status_ff <= status_in;
         target_ff <= target_in;
         value_ff  <= req_push_value;
      end
      if (done) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= is_pop ? tap_rd_data : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_value_ff;

endmodule

### tb/bounded_double_ended_queue_tb.sv
// Self-checking testbench for the bounded double-ended queue: directed and random traffic against a mirror model.
module bounded_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dqe_pkg::*;

   localparam int DEPTH       = 16;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;

   typedef enum logic [1:0] {
      STEP_REQUEST,
      STEP_CAPACITY,
      STEP_SETTLE
   } step_kind_type;

   typedef struct {
      step_kind_type     kind;
      op_type            op;
      logic [DATA_W-1:0] value;
      logic [CAP_W-1:0]  cap;
   } step_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] pop_value;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_capacity = CAP_RESET;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_PUSH_FRONT;
   logic [DATA_W-1:0]   req_push_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_pop_value;

   step_type  script[$];
   reply_type awaited_replies[$];

   // mirror of the queue contents and its capacity register
   logic [DATA_W-1:0] mirror_store [DEPTH];
   int                mirror_front;
   int                mirror_count;
   logic [CAP_W-1:0]  mirror_cap;

   int mismatch_count = 0;
   int requests_seen;
   int idle_cycles;

   bounded_double_ended_queue #(.DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the mirror and return the reply it must produce
   function automatic reply_type apply_deque_op(op_type op, logic [DATA_W-1:0] value);
      reply_type reply;
      int        room;
      int        slot;
      reply.status    = ST_FULL;
      reply.pop_value = '0;
      room = (int'(mirror_cap) > DEPTH) ? DEPTH : int'(mirror_cap);
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (mirror_count >= room) begin
               reply.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
               mirror_store[mirror_front] = value;
               mirror_count++;
               reply.status = ST_PUSHED_FRONT;
            end else begin
               slot = (mirror_front + mirror_count) % DEPTH;
               mirror_store[slot] = value;
               mirror_count++;
               reply.status = ST_PUSHED_BACK;
            end
         end
         default: begin
            if (mirror_count == 0) begin
               reply.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
               reply.pop_value = mirror_store[mirror_front];
               mirror_front = (mirror_front + 1) % DEPTH;
               mirror_count--;
               reply.status = ST_POPPED_FRONT;
            end else begin
               slot = (mirror_front + mirror_count - 1) % DEPTH;
               reply.pop_value = mirror_store[slot];
               mirror_count--;
               reply.status = ST_POPPED_BACK;
            end
         end
      endcase
      return reply;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic add_request(input op_type op, input logic [DATA_W-1:0] value);
      step_type s;
      s.kind  = STEP_REQUEST;
      s.op    = op;
      s.value = value;
      s.cap   = '0;
      script.insert(script.size(), s);
   endtask

   task automatic add_capacity(input logic [CAP_W-1:0] cap);
      step_type s;
      s.kind  = STEP_CAPACITY;
      s.op    = OP_PUSH_FRONT;
      s.value = '0;
      s.cap   = cap;
      script.insert(script.size(), s);
   endtask

   task automatic add_settle();
      step_type s;
      s.kind  = STEP_SETTLE;
      s.op    = OP_PUSH_FRONT;
      s.value = '0;
      s.cap   = '0;
      script.insert(script.size(), s);
   endtask

   // Driver: feed requests in bursts, write capacity only when the queue is quiet
   always @(posedge clock) begin : drive_proc
      logic slot_free;
      logic quiet;
      int   burst_left;
      int   gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         csr_valid  <= 1'b0;
         burst_left = 8;
         gap_left   = 0;
      end else begin
         slot_free = !(req_valid && !req_ready) && !(csr_valid && !csr_ready);
         if (slot_free) begin
            quiet = (awaited_replies.size() == 0) && !req_valid && !csr_valid;
            if (script.size() == 0) begin
               req_valid <= 1'b0;
               csr_valid <= 1'b0;
            end else if (script[0].kind == STEP_REQUEST) begin
               csr_valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
                  req_valid <= 1'b0;
               end else begin
                  req_valid      <= 1'b1;
                  req_operation  <= script[0].op;
                  req_push_value <= script[0].value;
                  script.delete(0);
                  burst_left--;
                  // start a new burst: now and then a long one with no gap
                  if (burst_left <= 0) begin
                     if ($urandom_range(0, 3) == 0) begin
                        burst_left = 40;
                        gap_left   = 0;
                     end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(1, 6);
                     end
                  end
               end
            end else begin
               req_valid <= 1'b0;
               if (script[0].kind == STEP_CAPACITY && quiet) begin
                  csr_valid    <= 1'b1;
                  csr_capacity <= script[0].cap;
                  script.delete(0);
               end else begin
                  csr_valid <= 1'b0;
                  // hold until every outstanding reply has come back
                  if (script[0].kind == STEP_SETTLE && quiet) begin
                     script.delete(0);
                  end
               end
            end
         end
      end
   end

   // Receiver: stall on a changing pattern, plus one long hold-off
   always @(posedge clock) begin : ready_proc
      int  seg_left;
      int  ready_mode;
      int  hold_left;
      logic long_hold_done;
      if (reset) begin
         rsp_ready      <= 1'b0;
         seg_left       = 0;
         ready_mode     = 0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && requests_seen >= 150) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left   = $urandom_range(10, 60);
            ready_mode = $urandom_range(0, 3);
         end else begin
            seg_left--;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= !rsp_ready;
         endcase
      end
   end

   // Monitor: track capacity writes, predict on each request, check each response
   always @(posedge clock) begin : monitor_proc
      reply_type want;
      if (reset) begin
         mirror_front  = 0;
         mirror_count  = 0;
         mirror_cap    = CAP_RESET;
         awaited_replies.delete();
         requests_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = awaited_replies[0];
               awaited_replies.delete(0);
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status got %0d want %0d (%s)",
                                            rsp_status, want.status, want.status.name()));
               end
               if (rsp_pop_value !== want.pop_value) begin
                  report_mismatch($sformatf("pop_value got %h want %h",
                                            rsp_pop_value, want.pop_value));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            mirror_cap = csr_capacity;
         end
         if (req_valid && req_ready) begin
            awaited_replies.insert(awaited_replies.size(),
                                   apply_deque_op(op_type'(req_operation), req_push_value));
            requests_seen <= requests_seen + 1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0]  phase_caps [8];
      int                phase_len;
      int                push_pct;
      op_type            op;
      logic [DATA_W-1:0] value;

      // empty pops, then extreme values through both ends
      add_request(OP_POP_FRONT,  $urandom());
      add_request(OP_POP_BACK,   $urandom());
      add_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      add_request(OP_PUSH_BACK,  32'h8000_0000);
      add_request(OP_PUSH_FRONT, 32'h0000_0000);
      add_request(OP_PUSH_BACK,  32'hFFFF_FFFF);
      add_request(OP_POP_FRONT,  $urandom());
      add_request(OP_POP_BACK,   $urandom());
      add_request(OP_POP_BACK,   $urandom());
      add_request(OP_POP_FRONT,  $urandom());

      // capacity zero refuses every push
      add_capacity(5'd0);
      add_request(OP_PUSH_FRONT, 32'h1234_5678);
      add_request(OP_PUSH_BACK,  32'h8765_4321);
      add_request(OP_POP_FRONT,  $urandom());

      // fill to a small capacity, then lower it below the count
      add_capacity(5'd3);
      add_request(OP_PUSH_BACK,  32'h5555_5555);
      add_request(OP_PUSH_BACK,  32'hAAAA_AAAA);
      add_request(OP_PUSH_BACK,  32'h0000_0001);
      add_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
      add_capacity(5'd1);
      add_request(OP_PUSH_BACK,  32'hCAFE_F00D);
      add_request(OP_POP_BACK,   $urandom());
      add_request(OP_POP_FRONT,  $urandom());
      add_request(OP_PUSH_FRONT, 32'h0BAD_CAFE);
      add_request(OP_POP_FRONT,  $urandom());

      // random phases, each under its own capacity; the first one saturates at DEPTH
      phase_caps[0] = 5'd31;
      phase_caps[1] = 5'd16;
      phase_caps[2] = 5'd1;
      phase_caps[3] = 5'd2;
      phase_caps[4] = 5'd8;
      phase_caps[5] = CAP_W'($urandom_range(1, 16));
      phase_caps[6] = CAP_W'($urandom_range(17, 30));
      phase_caps[7] = 5'd16;
      push_pct = 50;
      for (int p = 0; p < 8; p++) begin
         add_capacity(phase_caps[p]);
         phase_len = $urandom_range(50, 75);
         for (int i = 0; i < phase_len; i++) begin
            // swing between push-heavy and pop-heavy stretches to reach full and empty
            if (i % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0: push_pct = 75;
                  1: push_pct = 25;
                  default: push_pct = 50;
               endcase
            end
            if ($urandom_range(0, 99) < push_pct) begin
               op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
               op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            case ($urandom_range(0, 9))
               0: value = 32'h0000_0000;
               1: value = 32'hFFFF_FFFF;
               2: value = 32'h8000_0000;
               3: value = 32'h7FFF_FFFF;
               default: value = $urandom();
            endcase
            add_request(op, value);
            if (p == 4 && i == phase_len / 2) begin
               add_settle();
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: wait for all requests to go in and all replies to come back
      @(posedge clock);
      while (script.size() != 0 || req_valid || csr_valid || awaited_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * DEPTH + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### bounded_double_ended_queue.f
design/dqe_pkg.sv
design/dqe_cell.sv
design/dqe_ring.sv
design/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_tb.sv
